// File: design/evs_pkg.sv
// ============================================================================
// evs_pkg
// Shared types, constants, microcode program and table builder for the
// exponential variate sampler.
// ============================================================================
package evs_pkg;

    // Fixed field widths of the stream beats.
    localparam int UNIFORM_W = 32;
    localparam int VARIATE_W = 37;

    // Default configuration of the sampler.
    localparam int FRACTION_BITS_DEF = 32;
    localparam int TABLE_DEPTH_DEF   = 16;

    // Width of one multiplier digit in the final scaling pass.
    localparam int CHUNK_W = 16;

    // Largest representable variate, Q5.F saturation point.
    localparam logic [63:0] VARIATE_MAX = 64'h0000_001F_FFFF_FFFF;

    // ln2 as a Q0.64 fraction.
    localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;

    // Microcode program counter.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_TAKE_FIRST = 4'd0;
    localparam t_step STEP_NORM       = 4'd1;
    localparam t_step STEP_SPLIT      = 4'd2;
    localparam t_step STEP_TEST       = 4'd3;
    localparam t_step STEP_OPEN       = 4'd4;
    localparam t_step STEP_SEARCH     = 4'd5;
    localparam t_step STEP_CHECK      = 4'd6;
    localparam t_step STEP_MAC        = 4'd7;
    localparam t_step STEP_ROUND      = 4'd8;
    localparam t_step STEP_EMIT       = 4'd9;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_NORM,
        OP_SUB_ONE,
        OP_CLR_IDX,
        OP_OPEN_MIN,
        OP_MIN_STEP,
        OP_MAC,
        OP_ROUND,
        OP_EMIT
    } t_op;

    // Jump conditions.
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_U_ZERO,
        JC_NOT_NORM,
        JC_REM_LE_Q0,
        JC_SEARCH_ON,
        JC_MAC_MORE
    } t_jc;

    // One control word of the program.
    typedef struct packed {
        t_op   op;
        t_jc   jc;
        t_step target;
        logic  take_in;
        logic  give_out;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic u_zero;
        logic not_norm;
        logic rem_le_q0;
        logic search_on;
        logic mac_more;
    } t_flags;

    // The program: one control word per step.
    function automatic t_uword mc_rom(input t_step step);
        t_uword w;
        w = '{op: OP_NONE, jc: JC_ALWAYS, target: STEP_TAKE_FIRST,
              take_in: 1'b0, give_out: 1'b0};
        unique case (step)
            STEP_TAKE_FIRST: w = '{OP_LOAD,     JC_U_ZERO,    STEP_TAKE_FIRST, 1'b1, 1'b0};
            STEP_NORM:       w = '{OP_NORM,     JC_NOT_NORM,  STEP_NORM,       1'b0, 1'b0};
            STEP_SPLIT:      w = '{OP_SUB_ONE,  JC_NEVER,     STEP_TAKE_FIRST, 1'b0, 1'b0};
            STEP_TEST:       w = '{OP_CLR_IDX,  JC_REM_LE_Q0, STEP_EMIT,       1'b0, 1'b0};
            STEP_OPEN:       w = '{OP_OPEN_MIN, JC_NEVER,     STEP_TAKE_FIRST, 1'b1, 1'b0};
            STEP_SEARCH:     w = '{OP_MIN_STEP, JC_NEVER,     STEP_TAKE_FIRST, 1'b1, 1'b0};
            STEP_CHECK:      w = '{OP_NONE,     JC_SEARCH_ON, STEP_SEARCH,     1'b0, 1'b0};
            STEP_MAC:        w = '{OP_MAC,      JC_MAC_MORE,  STEP_MAC,        1'b0, 1'b0};
            STEP_ROUND:      w = '{OP_ROUND,    JC_NEVER,     STEP_TAKE_FIRST, 1'b0, 1'b0};
            STEP_EMIT:       w = '{OP_EMIT,     JC_ALWAYS,    STEP_TAKE_FIRST, 1'b0, 1'b1};
            default:         w = '{OP_NONE,     JC_ALWAYS,    STEP_TAKE_FIRST, 1'b0, 1'b0};
        endcase
        return w;
    endfunction

    // Next term of the series: hi / (j + 2), with a literal divisor per step.
    function automatic logic [63:0] next_term(input logic [63:0] hi, input int j);
        logic [63:0] t;
        case (j)
            0:       t = hi / 64'd2;
            1:       t = hi / 64'd3;
            2:       t = hi / 64'd4;
            3:       t = hi / 64'd5;
            4:       t = hi / 64'd6;
            5:       t = hi / 64'd7;
            6:       t = hi / 64'd8;
            7:       t = hi / 64'd9;
            8:       t = hi / 64'd10;
            9:       t = hi / 64'd11;
            10:      t = hi / 64'd12;
            11:      t = hi / 64'd13;
            12:      t = hi / 64'd14;
            13:      t = hi / 64'd15;
            14:      t = hi / 64'd16;
            default: t = 64'd0;
        endcase
        return t;
    endfunction

    // Cumulative table entry k in Q1.f: sum of ln2^j / j! for j = 1..k+1,
    // rounded to nearest. The last entry is exactly one. Elaboration only.
    function automatic logic [63:0] q_entry(input int k, input int f, input int depth);
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] prod;
        int           j;
        term = LN2_Q64;
        sum  = 64'd0;
        if (k == depth - 1) begin
            return 64'd1 << f;
        end
        for (j = 0; j <= k; j++) begin
            sum  = sum + term;
            prod = {64'd0, term} * {64'd0, LN2_Q64};
            term = next_term(prod[127:64], j);
        end
        return (sum >> (64 - f)) + ((sum >> (63 - f)) & 64'd1);
    endfunction

endpackage

// File: design/evs_stream_ifs.sv
// ============================================================================
// evs_stream_ifs
// Valid/ready stream interfaces for uniform input beats and variate
// output beats.
// ============================================================================

// Uniform sample stream.
interface evs_uniform_if;
    logic                            valid;
    logic                            ready;
    logic [evs_pkg::UNIFORM_W-1:0]   uniform;

    modport source (output valid, output uniform, input ready);
    modport sink   (input valid, input uniform, output ready);
endinterface

// Exponential variate stream.
interface evs_variate_if;
    logic                            valid;
    logic                            ready;
    logic [evs_pkg::VARIATE_W-1:0]   variate;

    modport source (output valid, output variate, input ready);
    modport sink   (input valid, input variate, output ready);
endinterface

// File: design/evs_sequencer.sv
// ============================================================================
// evs_sequencer
// Program counter and microcode table. Each step issues one datapath
// operation and picks the next step from a jump condition.
// ============================================================================
module evs_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_free,
    input  evs_pkg::t_flags i_flags,
    output evs_pkg::t_ctrl  o_ctrl
);

    evs_pkg::t_step  r_pc;
    evs_pkg::t_step  n_pc;
    evs_pkg::t_uword w_word;
    logic            w_fire;
    logic            w_jump;

    // Fetch the control word of the current step.
    assign w_word = evs_pkg::mc_rom(r_pc);

    // Take steps wait for an input beat, emit steps for a free output register; others run at once.
    always_comb begin
        if (w_word.take_in) begin
            w_fire = i_in_valid;
        end else if (w_word.give_out) begin
            w_fire = i_out_free;
        end else begin
            w_fire = 1'b1;
        end
    end

    // Evaluate the jump condition.
    always_comb begin
        unique case (w_word.jc)
            evs_pkg::JC_NEVER:     w_jump = 1'b0;
            evs_pkg::JC_ALWAYS:    w_jump = 1'b1;
            evs_pkg::JC_U_ZERO:    w_jump = i_flags.u_zero;
            evs_pkg::JC_NOT_NORM:  w_jump = i_flags.not_norm;
            evs_pkg::JC_REM_LE_Q0: w_jump = i_flags.rem_le_q0;
            evs_pkg::JC_SEARCH_ON: w_jump = i_flags.search_on;
            evs_pkg::JC_MAC_MORE:  w_jump = i_flags.mac_more;
            default:               w_jump = 1'b0;
        endcase
    end

    // Next step.
    always_comb begin
        if (!w_fire) begin
            n_pc = r_pc;
        end else if (w_jump) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + evs_pkg::t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= evs_pkg::STEP_TAKE_FIRST;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_in_ready  = w_word.take_in;
    assign o_ctrl.op   = w_word.op;
    assign o_ctrl.fire = w_fire;

endmodule

// File: design/evs_datapath.sv
// ============================================================================
// evs_datapath
// Registers and arithmetic of the sampler: doubling shifter, offset
// accumulator, running minimum, table compare, digit-serial scaling by ln2
// and the output register.
// ============================================================================
module evs_datapath #(
    parameter int FRACTION_BITS = evs_pkg::FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = evs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  evs_pkg::t_ctrl                i_ctrl,
    input  logic [evs_pkg::UNIFORM_W-1:0] i_uniform,
    output evs_pkg::t_flags               o_flags,
    input  logic                          i_out_ready,
    output logic                          o_out_free,
    output logic                          o_out_valid,
    output logic [evs_pkg::VARIATE_W-1:0] o_variate
);

    localparam int F   = FRACTION_BITS;
    localparam int UW  = evs_pkg::UNIFORM_W;
    localparam int CW  = evs_pkg::CHUNK_W;
    localparam int NCH = (F + CW - 1) / CW;
    localparam int MW  = NCH * CW;
    localparam int AW  = MW + F + 1;
    localparam int OW  = F + 6;
    localparam int SW  = F + 7;
    localparam int EW  = (SW > evs_pkg::VARIATE_W) ? SW : evs_pkg::VARIATE_W;
    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;

    localparam logic [F+1:0] ONE_V    = (F + 2)'(1) << F;
    localparam logic [F+1:0] COARSE_V = ONE_V >> 8;
    localparam logic [AW:0]  HALF_V   = (AW + 1)'(1) << (F - 1);

    // Cumulative table, constant per entry.
    logic [F:0] w_qtab [TABLE_DEPTH];
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_qtab
        assign w_qtab[k] = (F + 1)'(evs_pkg::q_entry(k, F, TABLE_DEPTH));
    end

    logic [F+1:0]  r_v;
    logic [OW-1:0] r_off;
    logic [F:0]    r_rem;
    logic [F:0]    r_add;
    logic [MW-1:0] r_min;
    logic [IW-1:0] r_idx;
    logic [AW-1:0] r_acc;
    logic [KW-1:0] r_cnt;
    logic          r_out_valid;
    logic [evs_pkg::VARIATE_W-1:0] r_out_data;

    logic [F+UW-1:0]   w_u_ext;
    logic [F-1:0]      w_u;
    logic [MW-1:0]     w_u_m;
    logic [CW-1:0]     w_chunk;
    logic [CW+F:0]     w_pp;
    logic [AW:0]       w_rnd;
    logic [EW-1:0]     w_sum;
    logic [evs_pkg::VARIATE_W-1:0] n_variate;
    logic              w_emit;

    // Only the low fraction bits of a uniform beat are used.
    assign w_u_ext = (F + UW)'(i_uniform);
    assign w_u     = w_u_ext[F-1:0];
    assign w_u_m   = MW'(w_u);

    // One digit of the minimum times ln2, most significant digit first.
    assign w_chunk = r_min[MW-1 -: CW];
    assign w_pp    = (CW + F + 1)'(w_chunk) * (CW + F + 1)'(w_qtab[0]);

    // Round the scaled minimum to nearest.
    assign w_rnd = (AW + 1)'(r_acc) + HALF_V;

    // Final sum with saturation to the output range.
    assign w_sum = EW'(r_off) + EW'(r_add);
    always_comb begin
        if (w_sum > EW'(evs_pkg::VARIATE_MAX)) begin
            n_variate = evs_pkg::VARIATE_MAX[evs_pkg::VARIATE_W-1:0];
        end else begin
            n_variate = w_sum[evs_pkg::VARIATE_W-1:0];
        end
    end

    // Status for the sequencer.
    assign o_flags.u_zero    = (w_u == '0);
    assign o_flags.not_norm  = (r_v <= ONE_V);
    assign o_flags.rem_le_q0 = (r_rem <= w_qtab[0]);
    assign o_flags.search_on = !((r_idx >= IW'(TABLE_DEPTH - 1)) ||
                                 (r_rem <= w_qtab[r_idx]));
    assign o_flags.mac_more  = (r_cnt != KW'(NCH - 1));

    // Working registers, updated by the issued operation.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            unique case (i_ctrl.op)
                evs_pkg::OP_LOAD: begin
                    r_v   <= (F + 2)'(w_u) << 1;
                    r_off <= '0;
                end
                evs_pkg::OP_NORM: begin
                    // Eight doublings at once while all of them stay at or below one.
                    if (r_v <= COARSE_V) begin
                        r_v   <= r_v << 8;
                        r_off <= r_off + (OW'(w_qtab[0]) << 3);
                    end else if (r_v <= ONE_V) begin
                        r_v   <= r_v << 1;
                        r_off <= r_off + OW'(w_qtab[0]);
                    end
                end
                evs_pkg::OP_SUB_ONE: begin
                    r_rem <= r_v[F:0] - ONE_V[F:0];
                    r_add <= r_v[F:0] - ONE_V[F:0];
                end
                evs_pkg::OP_CLR_IDX: begin
                    r_idx <= '0;
                end
                evs_pkg::OP_OPEN_MIN: begin
                    r_min <= w_u_m;
                end
                evs_pkg::OP_MIN_STEP: begin
                    if (w_u_m < r_min) begin
                        r_min <= w_u_m;
                    end
                    r_idx <= r_idx + IW'(1);
                    r_acc <= '0;
                    r_cnt <= '0;
                end
                evs_pkg::OP_MAC: begin
                    r_acc <= (r_acc << CW) + AW'(w_pp);
                    r_min <= r_min << CW;
                    r_cnt <= r_cnt + KW'(1);
                end
                evs_pkg::OP_ROUND: begin
                    r_add <= w_rnd[2*F:F];
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: holds a result until the sink takes the beat.
    assign w_emit = i_ctrl.fire && (i_ctrl.op == evs_pkg::OP_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= n_variate;
        end
    end

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_variate   = r_out_data;

endmodule

// File: design/exponential_variate_sampler.sv
// ============================================================================
// exponential_variate_sampler
// Standard exponential variates from uniform fractions by the Ahrens-Dieter
// SA method, run by a small microcoded sequencer over a fixed-point datapath.
// ============================================================================
// Each input beat carries one uniform fraction in (0,1); a draw consumes one
// or more beats and yields one Q5.F variate beat. The first uniform of a draw
// is normalized by doubling: eight doublings per cycle while nine or more
// remain, then one per cycle. A draw that ends on its first uniform runs
// take, normalize check, split, ln2 test and load of the output register.
// Otherwise the beat after it opens the minimum and each further beat is
// taken and then compared against the table. The closing scale of the
// minimum by ln2 runs on a 16-bit digit multiplier, then the result is
// rounded and loaded into the output register. The load waits while the
// output register still holds a beat the sink has not taken. A zero first
// uniform is taken and dropped. The output register lets the next draw
// start while a result still waits for the sink. No clearing pass follows
// reset.
// ============================================================================
module exponential_variate_sampler #(
    parameter int FRACTION_BITS = evs_pkg::FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = evs_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    evs_uniform_if.sink  i_uniform,
    evs_variate_if.source o_variate
);

    evs_pkg::t_ctrl  w_ctrl;
    evs_pkg::t_flags w_flags;
    logic            w_out_free;

    // Step counter and program.
    evs_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_uniform.valid),
        .o_in_ready (i_uniform.ready),
        .i_out_free (w_out_free),
        .i_flags    (w_flags),
        .o_ctrl     (w_ctrl)
    );

    // Arithmetic and output register.
    evs_datapath #(
        .FRACTION_BITS (FRACTION_BITS),
        .TABLE_DEPTH   (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_uniform   (i_uniform.uniform),
        .o_flags     (w_flags),
        .i_out_ready (o_variate.ready),
        .o_out_free  (w_out_free),
        .o_out_valid (o_variate.valid),
        .o_variate   (o_variate.variate)
    );

endmodule
